// ----- src/mips_cop0_exception_entry_core_defines.svh -----
// Assertion macros for the coprocessor 0 exception entry core.
// Included by the top level; no other dependencies.
`ifndef MIPS_COP0_EXCEPTION_ENTRY_CORE_DEFINES_SVH
`define MIPS_COP0_EXCEPTION_ENTRY_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define MCE_ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("mce: same-cycle check failed");
// Next-cycle implication.
`define MCE_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("mce: next-cycle check failed");
`else
`define MCE_ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define MCE_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif

`endif

// ----- src/mce_pkg.sv -----
// Shared types and constants for the coprocessor 0 exception entry core.
// No dependencies; used by every module of the block.
`default_nettype none

package mce_pkg;

  // Operation codes of an input transaction.
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_EXC  = 2'd1;
  localparam logic [1:0] OP_ERET = 2'd2;
  localparam logic [1:0] OP_NOP  = 2'd3;

  // Exception codes that have a vector.
  localparam logic [4:0] EXC_INT   = 5'd0;
  localparam logic [4:0] EXC_MOD   = 5'd1;
  localparam logic [4:0] EXC_TLBL  = 5'd2;
  localparam logic [4:0] EXC_TLBS  = 5'd3;
  localparam logic [4:0] EXC_ADEL  = 5'd4;
  localparam logic [4:0] EXC_ADES  = 5'd5;
  localparam logic [4:0] EXC_IBE   = 5'd6;
  localparam logic [4:0] EXC_DBE   = 5'd7;
  localparam logic [4:0] EXC_SYS   = 5'd8;
  localparam logic [4:0] EXC_BP    = 5'd9;
  localparam logic [4:0] EXC_RI    = 5'd10;
  localparam logic [4:0] EXC_CPU   = 5'd11;
  localparam logic [4:0] EXC_OV    = 5'd12;
  localparam logic [4:0] EXC_TR    = 5'd13;
  localparam logic [4:0] EXC_FPE   = 5'd15;
  localparam logic [4:0] EXC_WATCH = 5'd23;

  // Address regions from the top two bits of a virtual address.
  localparam logic [1:0] REGION_USER   = 2'd0;
  localparam logic [1:0] REGION_SUPER  = 2'd1;
  localparam logic [1:0] REGION_CSEG   = 2'd2;
  localparam logic [1:0] REGION_KERNEL = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_INT_MASK      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INT_ENABLE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_LEVEL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_USER_64BIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SUPER_64BIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_64BIT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOT_VECTORS  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMER_COMPARE = 3'd7;

  // Exception vectors.
  localparam logic [31:0] VEC_GENERAL = 32'h8000_0180;
  localparam logic [31:0] VEC_XTLB    = 32'h8000_0080;
  localparam logic [31:0] VEC_TLB     = 32'h8000_0000;

  localparam int unsigned COUNT_W = 33;

  // Input transaction payload.
  typedef struct packed {
    logic [1:0]         op;
    logic [4:0]         exc_code;
    logic [1:0]         cop_unit;
    logic signed [63:0] pc;
    logic               prev_delay_slot;
    logic [63:0]        bad_vaddr;
    logic               tlb_invalid;
    logic [6:0]         ext_pending;
  } in_t;

  // Result transaction payload.
  typedef struct packed {
    logic               exception_taken;
    logic signed [31:0] new_pc;
    logic signed [63:0] epc_out;
    logic               in_delay_slot;
    logic [4:0]         cause_code;
    logic [1:0]         cause_cop;
    logic               timer_irq;
    logic               fault;
  } out_t;

  // Status and compare settings.
  typedef struct packed {
    logic [7:0]  int_mask;
    logic        int_enable;
    logic        error_level;
    logic        user_64bit;
    logic        super_64bit;
    logic        kernel_64bit;
    logic        boot_vectors;
    logic [31:0] timer_compare;
  } cfg_t;

  // Architectural state changed by transactions.
  typedef struct packed {
    logic               exc_level;
    logic [COUNT_W-1:0] cycle_count;
    logic               ip7;
    logic [63:0]        epc;
    logic               branch_delay;
    logic [4:0]         code;
    logic [1:0]         cop;
  } state_t;

endpackage

`default_nettype wire

// ----- src/mce_cfg_regs.sv -----
// Configuration registers for status and compare settings.
// Depends on mce_pkg.
`default_nettype none

module mce_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [mce_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [mce_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output mce_pkg::cfg_t                       cfg_o,
  output logic                                compare_wr_o
);
  import mce_pkg::*;

  cfg_t cfg_q;

  // Register writes; each register keeps only its own low bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_INT_MASK:      cfg_q.int_mask      <= cfg_data_i[7:0];
        CFG_INT_ENABLE:    cfg_q.int_enable    <= cfg_data_i[0];
        CFG_ERROR_LEVEL:   cfg_q.error_level   <= cfg_data_i[0];
        CFG_USER_64BIT:    cfg_q.user_64bit    <= cfg_data_i[0];
        CFG_SUPER_64BIT:   cfg_q.super_64bit   <= cfg_data_i[0];
        CFG_KERNEL_64BIT:  cfg_q.kernel_64bit  <= cfg_data_i[0];
        CFG_BOOT_VECTORS:  cfg_q.boot_vectors  <= cfg_data_i[0];
        CFG_TIMER_COMPARE: cfg_q.timer_compare <= cfg_data_i[31:0];
        default: begin
        end
      endcase
    end
  end

  // A compare write clears the timer interrupt line.
  assign compare_wr_o = cfg_we_i && (cfg_idx_i == CFG_TIMER_COMPARE);
  assign cfg_o        = cfg_q;

endmodule

`default_nettype wire

// ----- src/mce_exc_logic.sv -----
// Combinational next-state and result logic for one transaction.
// Depends on mce_pkg.
`default_nettype none

module mce_exc_logic (
  input  wire mce_pkg::in_t    item_i,
  input  wire mce_pkg::cfg_t   cfg_i,
  input  wire mce_pkg::state_t state_i,
  output mce_pkg::state_t      state_o,
  output mce_pkg::out_t        result_o
);
  import mce_pkg::*;

  logic [COUNT_W-1:0] count_inc;
  logic               ip7_tick;
  logic [7:0]         pending;
  logic               irq;
  logic               enter;
  logic [4:0]         code_e;
  logic [1:0]         cop_e;
  logic               handled;
  logic               wide;
  logic [31:0]        vec;
  logic               taken;
  state_t             nxt;

  // Codes that have an exception vector.
  function automatic logic code_handled(input logic [4:0] code);
    logic ok;
    case (code)
      EXC_INT, EXC_MOD, EXC_TLBL, EXC_TLBS, EXC_ADEL, EXC_ADES, EXC_IBE,
      EXC_DBE, EXC_SYS, EXC_BP, EXC_RI, EXC_CPU, EXC_OV, EXC_TR, EXC_FPE,
      EXC_WATCH: ok = 1'b1;
      default:   ok = 1'b0;
    endcase
    return ok;
  endfunction

  // Timer tick and interrupt check.
  assign count_inc = state_i.cycle_count + COUNT_W'(1);
  assign ip7_tick  = state_i.ip7 || (count_inc == {cfg_i.timer_compare, 1'b0});
  assign pending   = {ip7_tick, item_i.ext_pending} & cfg_i.int_mask;
  assign irq       = (pending != 8'd0) && cfg_i.int_enable && !state_i.exc_level
                     && !cfg_i.error_level;

  assign enter  = ((item_i.op == OP_TICK) && irq) || (item_i.op == OP_EXC);
  assign code_e = (item_i.op == OP_EXC) ? item_i.exc_code : EXC_INT;
  assign cop_e  = (item_i.op == OP_EXC) ? item_i.cop_unit : 2'd0;

  // Refill vector width by address region.
  always_comb begin
    case (item_i.bad_vaddr[63:62])
      REGION_USER:   wide = cfg_i.user_64bit;
      REGION_SUPER:  wide = cfg_i.super_64bit;
      REGION_KERNEL: wide = cfg_i.kernel_64bit;
      default:       wide = 1'b0;
    endcase
  end

  // Vector selection; TLB load and store faults may use a refill vector.
  always_comb begin
    if ((code_e == EXC_TLBL) || (code_e == EXC_TLBS)) begin
      if (state_i.exc_level || item_i.tlb_invalid) begin
        vec = VEC_GENERAL;
      end else if (wide) begin
        vec = VEC_XTLB;
      end else begin
        vec = VEC_TLB;
      end
    end else begin
      vec = VEC_GENERAL;
    end
  end

  assign handled = code_handled(code_e) && !cfg_i.boot_vectors;
  assign taken   = enter && handled;

  // Next state.
  always_comb begin
    nxt = state_i;
    case (item_i.op)
      OP_TICK: begin
        nxt.cycle_count = count_inc;
        nxt.ip7         = ip7_tick;
      end
      OP_ERET: begin
        nxt.exc_level = 1'b0;
      end
      default: begin
      end
    endcase
    if (enter) begin
      // A nested entry keeps EPC and the branch delay bit.
      if (!state_i.exc_level) begin
        nxt.branch_delay = item_i.prev_delay_slot;
        nxt.epc = item_i.prev_delay_slot ? (item_i.pc - 64'd4) : item_i.pc;
      end
      nxt.exc_level = 1'b1;
      nxt.code      = code_e;
      nxt.cop       = cop_e;
    end
  end

  assign state_o = nxt;

  // Result fields reflect the state after this transaction.
  assign result_o.exception_taken = taken;
  assign result_o.new_pc          = taken ? vec : 32'd0;
  assign result_o.epc_out         = nxt.epc;
  assign result_o.in_delay_slot   = nxt.branch_delay;
  assign result_o.cause_code      = nxt.code;
  assign result_o.cause_cop       = nxt.cop;
  assign result_o.timer_irq       = nxt.ip7;
  assign result_o.fault           = enter && !handled;

endmodule

`default_nettype wire

// ----- src/mips_cop0_exception_entry_core.sv -----
// Top level of the coprocessor 0 exception entry and count/compare core.
// Depends on mce_pkg, mce_cfg_regs, mce_exc_logic and the defines header.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+--------------------
//   in      | input     | in_valid_i / in_stall_o   | in_data_i (in_t)
//   out     | output    | out_valid_o / out_stall_i | out_data_o (out_t)
//   cfg     | input     | cfg_we_i, no wait         | cfg_idx_i, cfg_data_i
//
// Each transaction passes through the input register and then the output
// register; while the output is not stalled, one per clock is sustained.
// The state registers are updated at the edge that moves a transaction from the
// input register into the output register, so back-to-back items see each
// other's effects. Reset clears the state, the settings and both valid flags.
// A stall on the output holds the result; the input stalls only when its
// register is full and cannot drain.
`default_nettype none

`include "mips_cop0_exception_entry_core_defines.svh"

module mips_cop0_exception_entry_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire mce_pkg::in_t                   in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output mce_pkg::out_t                       out_data_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [mce_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [mce_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import mce_pkg::*;

  cfg_t   cfg;
  logic   compare_wr;
  in_t    in_q;
  logic   in_valid_q;
  state_t st_q;
  state_t st_d;
  state_t st_nxt;
  out_t   res;
  out_t   out_q;
  logic   out_valid_q;
  logic   advance;
  logic   in_take;

  mce_cfg_regs u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .cfg_o        (cfg),
    .compare_wr_o (compare_wr)
  );

  mce_exc_logic u_logic (
    .item_i   (in_q),
    .cfg_i    (cfg),
    .state_i  (st_q),
    .state_o  (st_nxt),
    .result_o (res)
  );

  // Flow control between the input and output registers.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
  end

  // Next architectural state; a compare write clears the timer line.
  always_comb begin
    st_d = st_q;
    if (advance) begin
      st_d = st_nxt;
    end
    if (compare_wr) begin
      st_d.ip7 = 1'b0;
    end
  end

  // Architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks on the block's own logic.
  `MCE_ASSERT_NEXT(a_taken_sets_exl, clk_i, rst_ni, advance && res.exception_taken, st_q.exc_level)
  `MCE_ASSERT_IMPLIES(a_stall_only_blocked, clk_i, rst_ni, in_stall_o, out_valid_q && out_stall_i)
  `MCE_ASSERT_NEXT(a_count_only_on_tick, clk_i, rst_ni, !(advance && (in_q.op == OP_TICK)), $stable(st_q.cycle_count))
  `MCE_ASSERT_NEXT(a_compare_clears_ip7, clk_i, rst_ni, compare_wr, !st_q.ip7)

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the coprocessor 0 exception entry and timer core.
// Depends on mce_pkg and mips_cop0_exception_entry_core; predicts every result
// from its own copy of the status, cause, EPC and count state.
`default_nettype none

module testbench;
  import mce_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Receiver stall patterns.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  in_t                   in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_t                  out_data_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // Transactions waiting to be offered, and results still owed by the block.
  in_t  pending_items[$];
  out_t expected_results[$];

  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;

  // Predicted architectural state and settings.
  cfg_t        cop0_cfg = '0;
  logic        exc_level_q = 1'b0;
  logic [32:0] cycle_count_q = '0;
  logic        ip7_q = 1'b0;
  logic [63:0] epc_q = '0;
  logic        branch_delay_q = 1'b0;
  logic [4:0]  code_q = '0;
  logic [1:0]  cop_q = '0;

  // Exception codes that have a vector.
  logic [4:0] handled_codes [16] = '{EXC_INT, EXC_MOD, EXC_TLBL, EXC_TLBS, EXC_ADEL,
                                     EXC_ADES, EXC_IBE, EXC_DBE, EXC_SYS, EXC_BP,
                                     EXC_RI, EXC_CPU, EXC_OV, EXC_TR, EXC_FPE,
                                     EXC_WATCH};

  mips_cop0_exception_entry_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // Exception entry: updates EPC and cause, returns 1 with the vector, or 0 on a fault.
  function automatic logic enter_exception(input logic [4:0] code, input logic [1:0] cop,
                                           input in_t item, output logic [31:0] vector);
    logic was_exl;
    logic wide;
    was_exl = exc_level_q;
    vector = '0;
    if (!was_exl) begin
      branch_delay_q = item.prev_delay_slot;
      epc_q = item.prev_delay_slot ? item.pc - 64'd4 : item.pc;
    end
    exc_level_q = 1'b1;
    cop_q = cop;
    code_q = code;
    case (item.bad_vaddr[63:62])
      REGION_USER:   wide = cop0_cfg.user_64bit;
      REGION_SUPER:  wide = cop0_cfg.super_64bit;
      REGION_KERNEL: wide = cop0_cfg.kernel_64bit;
      default:       wide = 1'b0;
    endcase
    if (cop0_cfg.boot_vectors) return 1'b0;
    case (code)
      EXC_INT, EXC_MOD, EXC_ADEL, EXC_ADES, EXC_IBE, EXC_DBE, EXC_SYS, EXC_BP,
      EXC_RI, EXC_CPU, EXC_OV, EXC_TR, EXC_FPE, EXC_WATCH: vector = VEC_GENERAL;
      EXC_TLBL, EXC_TLBS: begin
        if (was_exl || item.tlb_invalid) vector = VEC_GENERAL;
        else vector = wide ? VEC_XTLB : VEC_TLB;
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // Works out the result of one transaction and advances the predicted state.
  function automatic out_t predict_cop0(input in_t item);
    out_t        res;
    logic        taken;
    logic        flt;
    logic [31:0] vector;
    logic [7:0]  pend;
    taken = 1'b0;
    flt = 1'b0;
    vector = '0;
    case (item.op)
      OP_TICK: begin
        cycle_count_q = cycle_count_q + 33'd1;
        if (cycle_count_q == {cop0_cfg.timer_compare, 1'b0}) ip7_q = 1'b1;
        pend = {ip7_q, item.ext_pending} & cop0_cfg.int_mask;
        if (pend != 8'd0 && cop0_cfg.int_enable && !exc_level_q && !cop0_cfg.error_level) begin
          taken = enter_exception(EXC_INT, 2'd0, item, vector);
          flt = !taken;
        end
      end
      OP_EXC: begin
        taken = enter_exception(item.exc_code, item.cop_unit, item, vector);
        flt = !taken;
      end
      OP_ERET: exc_level_q = 1'b0;
      default: ;
    endcase
    res.exception_taken = taken;
    res.new_pc = taken ? vector : 32'd0;
    res.epc_out = epc_q;
    res.in_delay_slot = branch_delay_q;
    res.cause_code = code_q;
    res.cause_cop = cop_q;
    res.timer_irq = ip7_q;
    res.fault = flt;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= 50)
      $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
  endtask

  // One register write; the block is idle, so the predictor takes it at once.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_INT_MASK:      cop0_cfg.int_mask = data[7:0];
      CFG_INT_ENABLE:    cop0_cfg.int_enable = data[0];
      CFG_ERROR_LEVEL:   cop0_cfg.error_level = data[0];
      CFG_USER_64BIT:    cop0_cfg.user_64bit = data[0];
      CFG_SUPER_64BIT:   cop0_cfg.super_64bit = data[0];
      CFG_KERNEL_64BIT:  cop0_cfg.kernel_64bit = data[0];
      CFG_BOOT_VECTORS:  cop0_cfg.boot_vectors = data[0];
      CFG_TIMER_COMPARE: begin
        cop0_cfg.timer_compare = data;
        ip7_q = 1'b0;
      end
      default: ;
    endcase
  endtask

  // Writes every register, with random junk in the unused upper bits.
  task automatic load_settings(input cfg_t c);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(CFG_INT_MASK, {junk[31:8], c.int_mask});
    write_reg(CFG_INT_ENABLE, {junk[31:1], c.int_enable});
    junk = $urandom;
    write_reg(CFG_ERROR_LEVEL, {junk[31:1], c.error_level});
    write_reg(CFG_USER_64BIT, {junk[30:0], c.user_64bit});
    junk = $urandom;
    write_reg(CFG_SUPER_64BIT, {junk[31:1], c.super_64bit});
    write_reg(CFG_KERNEL_64BIT, {junk[30:0], c.kernel_64bit});
    junk = $urandom;
    write_reg(CFG_BOOT_VECTORS, {junk[31:1], c.boot_vectors});
    write_reg(CFG_TIMER_COMPARE, c.timer_compare);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Holds the sender back until every queued transaction has produced its result.
  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic in_t make_item(input logic [1:0] op, input logic [4:0] code,
                                    input logic [63:0] pc, input logic dslot,
                                    input logic [63:0] badv, input logic tlbinv,
                                    input logic [6:0] ext);
    in_t item;
    item.op = op;
    item.exc_code = code;
    item.cop_unit = 2'($urandom_range(0, 3));
    item.pc = pc;
    item.prev_delay_slot = dslot;
    item.bad_vaddr = badv;
    item.tlb_invalid = tlbinv;
    item.ext_pending = ext;
    return item;
  endfunction

  // Mostly ticks and exceptions, with enough returns to reopen interrupts.
  function automatic in_t random_item();
    in_t     item;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) item.op = OP_TICK;
    else if (sel < 75) item.op = OP_EXC;
    else if (sel < 95) item.op = OP_ERET;
    else item.op = OP_NOP;
    sel = $urandom_range(0, 99);
    if (sel < 25) item.exc_code = sel[0] ? EXC_TLBL : EXC_TLBS;
    else if (sel < 75) item.exc_code = handled_codes[$urandom_range(0, 15)];
    else item.exc_code = 5'($urandom_range(0, 31));
    item.cop_unit = 2'($urandom_range(0, 3));
    item.pc = {$urandom, $urandom};
    item.prev_delay_slot = 1'($urandom_range(0, 1));
    item.bad_vaddr = {$urandom, $urandom};
    item.tlb_invalid = ($urandom_range(0, 3) == 0);
    item.ext_pending = ($urandom_range(0, 1) == 0) ? 7'd0 : 7'($urandom);
    return item;
  endfunction

  // Settings for one random phase; outside phases one and four the compare value is put ahead.
  function automatic cfg_t random_settings(input int phase);
    cfg_t c;
    c.int_mask = (phase == 0) ? 8'hFF : (phase == 1) ? 8'h00 : 8'($urandom);
    c.int_enable = ($urandom_range(0, 3) != 0);
    c.error_level = ($urandom_range(0, 5) == 0);
    c.user_64bit = 1'($urandom_range(0, 1));
    c.super_64bit = 1'($urandom_range(0, 1));
    c.kernel_64bit = 1'($urandom_range(0, 1));
    c.boot_vectors = (phase == 3);
    if (phase == 1) c.timer_compare = 32'hFFFF_FFFF;
    else if (phase == 4) c.timer_compare = 32'd0;
    else c.timer_compare = cycle_count_q[32:1] + 32'($urandom_range(1, 60));
    return c;
  endfunction

  // Driver: offers queued transactions in bursts with random gaps.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) expected_results.push_back(predict_cop0(in_data_i));
    if (!in_valid_i || !in_stall_o) begin
      if (burst_left != 0 && pending_items.size() != 0) begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_items.pop_front();
        burst_left--;
      end else begin
        in_valid_i <= 1'b0;
        if (gap_left != 0) begin
          gap_left--;
        end else begin
          burst_left = $urandom_range(1, 48);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // Receiver: switches between random stall patterns, with one long hold-off
  // while the sender keeps offering so that the block backs up.
  stall_mode_e stall_mode = STALL_NONE;
  int unsigned stall_cycle = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  always @(posedge clk_i) begin
    stall_cycle++;
    if (stall_cycle[5:0] == 6'd0) stall_mode = stall_mode_e'($urandom_range(0, 3));
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (!hold_done && results_seen >= 400 && in_valid_i) begin
      hold_done = 1'b1;
      hold_left = 150;
      out_stall_i <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_RANDOM:   out_stall_i <= ($urandom_range(0, 3) == 0);
        STALL_PERIODIC: out_stall_i <= (stall_cycle[1:0] == 2'b11);
        STALL_HEAVY:    out_stall_i <= ($urandom_range(0, 9) < 7);
        default:        out_stall_i <= 1'b0;
      endcase
    end
  end

  // Monitor: checks each accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    out_t want;
    if (out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transaction", 64'(out_data_o), 64'd0);
      end else begin
        want = expected_results.pop_front();
        if (out_data_o.exception_taken !== want.exception_taken)
          report_mismatch("exception_taken", 64'(out_data_o.exception_taken),
                          64'(want.exception_taken));
        if (out_data_o.new_pc !== want.new_pc)
          report_mismatch("new_pc", 64'(out_data_o.new_pc), 64'(want.new_pc));
        if (out_data_o.epc_out !== want.epc_out)
          report_mismatch("epc_out", out_data_o.epc_out, want.epc_out);
        if (out_data_o.in_delay_slot !== want.in_delay_slot)
          report_mismatch("in_delay_slot", 64'(out_data_o.in_delay_slot),
                          64'(want.in_delay_slot));
        if (out_data_o.cause_code !== want.cause_code)
          report_mismatch("cause_code", 64'(out_data_o.cause_code), 64'(want.cause_code));
        if (out_data_o.cause_cop !== want.cause_cop)
          report_mismatch("cause_cop", 64'(out_data_o.cause_cop), 64'(want.cause_cop));
        if (out_data_o.timer_irq !== want.timer_irq)
          report_mismatch("timer_irq", 64'(out_data_o.timer_irq), 64'(want.timer_irq));
        if (out_data_o.fault !== want.fault)
          report_mismatch("fault", 64'(out_data_o.fault), 64'(want.fault));
      end
    end
  end

  // Stimulus: directed cases, then random phases with fresh settings each time.
  initial begin
    in_t  item;
    cfg_t c;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: everything masked, all 32-bit refill vectors.
    item = '1;
    item.op = OP_NOP;
    pending_items.push_back(item);
    pending_items.push_back(make_item(OP_TICK, EXC_INT, '1, 1'b0, '0, 1'b0, 7'h7F));
    pending_items.push_back(make_item(OP_EXC, EXC_SYS, 64'h0123_4567_89AB_CDEF, 1'b1,
                                      '0, 1'b0, 7'h00));
    // Nested TLB miss keeps EPC and takes the general vector.
    pending_items.push_back(make_item(OP_EXC, EXC_TLBL, 64'h1111, 1'b0,
                                      64'hC000_0000_0000_0000, 1'b0, 7'h00));
    pending_items.push_back(make_item(OP_ERET, EXC_INT, '0, 1'b0, '0, 1'b0, 7'h00));
    pending_items.push_back(make_item(OP_EXC, EXC_TLBL, 64'h2222, 1'b0, '0, 1'b0, 7'h00));
    pending_items.push_back(make_item(OP_ERET, EXC_INT, '0, 1'b0, '0, 1'b0, 7'h00));
    // Unlisted code faults but still records EPC and cause.
    pending_items.push_back(make_item(OP_EXC, 5'd31, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0,
                                      '1, 1'b1, 7'h00));
    pending_items.push_back(make_item(OP_ERET, EXC_INT, '0, 1'b0, '0, 1'b0, 7'h00));
    // Delay slot at address zero wraps the EPC.
    pending_items.push_back(make_item(OP_EXC, EXC_WATCH, '0, 1'b1, '0, 1'b0, 7'h00));
    pending_items.push_back(make_item(OP_ERET, EXC_INT, '0, 1'b0, '0, 1'b0, 7'h00));
    wait_drained();

    // Timer interrupt: compare set so that the third tick reaches it, only ip7 unmasked.
    c = '0;
    c.int_mask = 8'h80;
    c.int_enable = 1'b1;
    c.user_64bit = 1'b1;
    c.super_64bit = 1'b1;
    c.kernel_64bit = 1'b1;
    c.timer_compare = cycle_count_q[32:1] + 32'd2;
    load_settings(c);
    repeat (3) pending_items.push_back(make_item(OP_TICK, EXC_INT, 64'h8000_0000_0000_0000,
                                                 1'b0, '0, 1'b0, 7'h00));
    pending_items.push_back(make_item(OP_ERET, EXC_INT, '0, 1'b0, '0, 1'b0, 7'h00));
    // The timer line stays set, so the next tick interrupts again.
    pending_items.push_back(make_item(OP_TICK, EXC_INT, 64'h40, 1'b1, '0, 1'b0, 7'h00));
    pending_items.push_back(make_item(OP_ERET, EXC_INT, '0, 1'b0, '0, 1'b0, 7'h00));
    // Refill vector per region; region two never uses the 64-bit vector.
    for (int r = 0; r < 4; r++) begin
      pending_items.push_back(make_item(OP_EXC, EXC_TLBS, 64'h1000, 1'b0,
                                        {2'(r), 62'h1234}, 1'b0, 7'h00));
      pending_items.push_back(make_item(OP_ERET, EXC_INT, '0, 1'b0, '0, 1'b0, 7'h00));
    end
    wait_drained();

    // Error level blocks interrupts; boot vectors turn an exception into a fault.
    c = '0;
    c.int_mask = 8'hFF;
    c.int_enable = 1'b1;
    c.error_level = 1'b1;
    c.boot_vectors = 1'b1;
    c.timer_compare = 32'hFFFF_FFFF;
    load_settings(c);
    pending_items.push_back(make_item(OP_TICK, EXC_INT, 64'h3000, 1'b0, '0, 1'b0, 7'h7F));
    pending_items.push_back(make_item(OP_EXC, EXC_BP, 64'h3004, 1'b0, '0, 1'b0, 7'h00));
    pending_items.push_back(make_item(OP_ERET, EXC_INT, '0, 1'b0, '0, 1'b0, 7'h00));
    wait_drained();

    // An interrupt taken with boot vectors set faults as well.
    c.error_level = 1'b0;
    c.int_mask = 8'h7F;
    c.timer_compare = 32'd0;
    load_settings(c);
    pending_items.push_back(make_item(OP_TICK, EXC_INT, 64'h5000, 1'b1, '0, 1'b0, 7'h01));
    pending_items.push_back(make_item(OP_ERET, EXC_INT, '0, 1'b0, '0, 1'b0, 7'h00));
    wait_drained();

    // Random phases; each ends with the sender paused until the block is empty.
    for (int phase = 0; phase < 5; phase++) begin
      load_settings(random_settings(phase));
      repeat (245) pending_items.push_back(random_item());
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+src
src/mce_pkg.sv
src/mce_cfg_regs.sv
src/mce_exc_logic.sv
src/mips_cop0_exception_entry_core.sv
tb/testbench.sv
